/* rtl/core/mhr_pkg.sv */
package mhr_pkg;

    localparam int NUM_REGS       = 5;
    localparam int MAX_READ_COUNT = 31;
    localparam int NOTIFY_ADDR    = 3;
    localparam int REG_IDX_W      = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int CQ_DEPTH       = 2;
    localparam int CQ_PTR_W       = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
    localparam int CQ_CNT_W       = $clog2(CQ_DEPTH + 1);
    localparam int RESP_IDX_W     = $clog2(2 * MAX_READ_COUNT + 2);

    localparam logic [7:0] FN_READ   = 8'h03;
    localparam logic [7:0] FN_WRITE1 = 8'h06;
    localparam logic [7:0] FN_WRITEN = 8'h10;
    localparam logic [7:0] EXC_CODE  = 8'h83;
    localparam logic [7:0] EXC_FUNC  = 8'h01;
    localparam logic [7:0] EXC_ADDR  = 8'h02;
    localparam logic [7:0] EXC_COUNT = 8'h03;

    localparam logic [15:0] UNMAPPED_VALUE = 16'hFFFF;
    localparam logic [15:0] OFFSET_MAX     = 16'hFFFF;

    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] idx;
        logic [15:0]          data;
    } reg_wr_t;

    typedef struct packed {
        logic        is_clear;
        logic [7:0]  func;
        logic [15:0] start_addr;
        logic [15:0] reg_count;
        logic        write_error;
        logic [14:0] done;
    } cmd_t;

    function automatic logic addr_mapped(logic [15:0] a);
        return (a >= 16'd1) && (a <= 16'(NUM_REGS));
    endfunction

    function automatic logic [REG_IDX_W-1:0] reg_index(logic [15:0] a);
        logic [15:0] d;
        d = a - 16'd1;
        return d[REG_IDX_W-1:0];
    endfunction

endpackage

/* rtl/core/mhr_regfile.sv */
module mhr_regfile
    import mhr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  reg_wr_t              wr,
    input  logic                 notify_clr,
    input  logic [REG_IDX_W-1:0] rd_idx,
    output logic [15:0]          rd_data,
    output logic                 notify
);

    localparam logic NOTIFY_MAPPED = (NOTIFY_ADDR <= NUM_REGS);

    logic [15:0] regs_reg [NUM_REGS];
    logic        notify_reg;
    logic        notify_hit;

    assign notify_hit = NOTIFY_MAPPED && wr.en &&
                        (wr.idx == REG_IDX_W'(NOTIFY_ADDR - 1));
    assign rd_data    = (rd_idx <= REG_IDX_W'(NUM_REGS - 1)) ? regs_reg[rd_idx] : '0;
    assign notify     = notify_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NUM_REGS; r++)
            begin
                regs_reg[r] <= '0;
            end
            notify_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                regs_reg[wr.idx] <= wr.data;
            end
            if (notify_hit)
            begin
                notify_reg <= 1'b1;
            end
            else if (notify_clr)
            begin
                notify_reg <= 1'b0;
            end
        end
    end

endmodule

/* rtl/core/mhr_front.sv */
module mhr_front
    import mhr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       mode,
    input  logic [7:0] frame_byte,
    input  logic       frame_last,
    input  logic       busy,
    input  logic       cq_full,
    output logic       full,
    output logic       cmd_push,
    output cmd_t       cmd,
    output reg_wr_t    reg_wr
);

    logic [15:0] off_reg, off_next;
    logic [7:0]  func_reg, func_next;
    logic [15:0] start_reg, start_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  hold_reg, hold_next;
    logic        werr_reg, werr_next;

    logic        accept;
    logic [14:0] widx;
    logic [15:0] waddr;

    assign full   = cq_full || (busy && (off_reg >= 16'd13));
    assign accept = push && !full;
    assign widx   = off_reg[15:1] - 15'd7;
    assign waddr  = start_reg + {1'b0, widx};

    always_comb
    begin
        off_next   = off_reg;
        func_next  = func_reg;
        start_next = start_reg;
        count_next = count_reg;
        hold_next  = hold_reg;
        werr_next  = werr_reg;
        cmd_push   = 1'b0;
        cmd        = '0;
        reg_wr     = '0;
        if (accept)
        begin
            if (mode)
            begin
                cmd_push     = 1'b1;
                cmd.is_clear = 1'b1;
            end
            else
            begin
                if (off_reg != OFFSET_MAX)
                begin
                    priority if (off_reg == 16'd7)
                    begin
                        func_next = frame_byte;
                    end
                    else if (off_reg == 16'd8)
                    begin
                        start_next[15:8] = frame_byte;
                    end
                    else if (off_reg == 16'd9)
                    begin
                        start_next[7:0] = frame_byte;
                    end
                    else if (off_reg == 16'd10)
                    begin
                        count_next[15:8] = frame_byte;
                    end
                    else if (off_reg == 16'd11)
                    begin
                        count_next[7:0] = frame_byte;
                    end
                    else if ((off_reg >= 16'd13) && off_reg[0])
                    begin
                        hold_next = frame_byte;
                    end
                    else if (off_reg >= 16'd14)
                    begin
                        if ((func_reg == FN_WRITEN) && !werr_reg &&
                            ({1'b0, widx} < count_reg))
                        begin
                            if (addr_mapped(waddr))
                            begin
                                reg_wr.en   = 1'b1;
                                reg_wr.idx  = reg_index(waddr);
                                reg_wr.data = {hold_reg, frame_byte};
                            end
                            else
                            begin
                                werr_next = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        hold_next = hold_reg;
                    end
                    off_next = off_reg + 16'd1;
                end
                if (frame_last)
                begin
                    cmd_push        = 1'b1;
                    cmd.func        = func_next;
                    cmd.start_addr  = start_next;
                    cmd.reg_count   = count_next;
                    cmd.write_error = werr_next;
                    if (off_next >= 16'd15)
                    begin
                        cmd.done = 15'((off_next - 16'd13) >> 1);
                    end
                    off_next   = '0;
                    func_next  = '0;
                    start_next = '0;
                    count_next = '0;
                    hold_next  = '0;
                    werr_next  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg   <= '0;
            func_reg  <= '0;
            start_reg <= '0;
            count_reg <= '0;
            hold_reg  <= '0;
            werr_reg  <= 1'b0;
        end
        else
        begin
            off_reg   <= off_next;
            func_reg  <= func_next;
            start_reg <= start_next;
            count_reg <= count_next;
            hold_reg  <= hold_next;
            werr_reg  <= werr_next;
        end
    end

endmodule

/* rtl/core/mhr_cmd_queue.sv */
module mhr_cmd_queue
    import mhr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t din,
    output logic full,
    input  logic pop,
    output cmd_t dout,
    output logic empty
);

    cmd_t                entries_reg [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] wr_ptr_reg;
    logic [CQ_PTR_W-1:0] rd_ptr_reg;
    logic [CQ_CNT_W-1:0] count_reg;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == CQ_CNT_W'(CQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign dout    = entries_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                entries_reg[wr_ptr_reg] <= din;
                wr_ptr_reg <= (wr_ptr_reg == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 :
                              wr_ptr_reg + CQ_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 :
                              rd_ptr_reg + CQ_PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CQ_CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CQ_CNT_W'(1);
            end
        end
    end

endmodule

/* rtl/core/mhr_back.sv */
module mhr_back
    import mhr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  cmd_t                 cmd,
    output logic                 cmd_pop,
    output reg_wr_t              reg_wr,
    output logic                 notify_clr,
    output logic [REG_IDX_W-1:0] rd_idx,
    input  logic [15:0]          rd_data,
    input  logic                 notify,
    output logic                 busy,
    output logic                 empty,
    input  logic                 pop,
    output logic [7:0]           resp_byte,
    output logic                 resp_last,
    output logic                 write_notify
);

    typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_EMIT} state_t;
    typedef enum logic [1:0] {RK_EXC, RK_ECHO, RK_READ} kind_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       notify;
    } out_item_t;

    state_t                state_reg;
    kind_t                 kind_reg;
    logic [7:0]            code_reg;
    logic [15:0]           start_reg;
    logic [15:0]           count_reg;
    logic [15:0]           addr_reg;
    logic [RESP_IDX_W-1:0] k_reg;
    logic [RESP_IDX_W-1:0] last_k_reg;
    logic [15:0]           chk_s_reg;
    logic [15:0]           chk_l_reg;
    logic                  chk_err_reg;

    out_item_t             oq_reg [2];
    logic                  oq_wr_reg;
    logic                  oq_rd_reg;
    logic [1:0]            oq_cnt_reg;

    logic                  oq_full;
    logic                  produce;
    logic                  oq_pop;
    logic                  chk_fail;
    logic [15:0]           rd_value;
    logic [7:0]            byte_sel;
    out_item_t             item;

    assign busy     = (state_reg != ST_IDLE);
    assign cmd_pop  = (state_reg == ST_IDLE) && cmd_valid;
    assign notify_clr = cmd_pop && cmd.is_clear;
    assign rd_idx   = reg_index(addr_reg);
    assign rd_value = addr_mapped(addr_reg) ? rd_data : UNMAPPED_VALUE;
    assign chk_fail = chk_err_reg ||
                      ((chk_l_reg != '0) && ((chk_s_reg == '0) ||
                       (({1'b0, chk_l_reg} + {1'b0, chk_s_reg}) > 17'(NUM_REGS + 1))));

    assign oq_full  = (oq_cnt_reg == 2'd2);
    assign empty    = (oq_cnt_reg == 2'd0);
    assign oq_pop   = pop && !empty;
    assign produce  = (state_reg == ST_EMIT) && !oq_full;
    assign resp_byte    = oq_reg[oq_rd_reg].data;
    assign resp_last    = oq_reg[oq_rd_reg].last;
    assign write_notify = oq_reg[oq_rd_reg].notify;

    always_comb
    begin
        reg_wr = '0;
        if (cmd_pop && !cmd.is_clear && (cmd.func == FN_WRITE1) &&
            addr_mapped(cmd.start_addr))
        begin
            reg_wr.en   = 1'b1;
            reg_wr.idx  = reg_index(cmd.start_addr);
            reg_wr.data = cmd.reg_count;
        end
    end

    always_comb
    begin
        byte_sel = '0;
        unique case (kind_reg)
            RK_EXC:
            begin
                byte_sel = (k_reg == '0) ? EXC_CODE : code_reg;
            end
            RK_ECHO:
            begin
                priority if (k_reg == RESP_IDX_W'(0))
                begin
                    byte_sel = code_reg;
                end
                else if (k_reg == RESP_IDX_W'(1))
                begin
                    byte_sel = start_reg[15:8];
                end
                else if (k_reg == RESP_IDX_W'(2))
                begin
                    byte_sel = start_reg[7:0];
                end
                else if (k_reg == RESP_IDX_W'(3))
                begin
                    byte_sel = count_reg[15:8];
                end
                else
                begin
                    byte_sel = count_reg[7:0];
                end
            end
            RK_READ:
            begin
                priority if (k_reg == RESP_IDX_W'(0))
                begin
                    byte_sel = FN_READ;
                end
                else if (k_reg == RESP_IDX_W'(1))
                begin
                    byte_sel = {count_reg[6:0], 1'b0};
                end
                else if (k_reg[0])
                begin
                    byte_sel = rd_value[7:0];
                end
                else
                begin
                    byte_sel = rd_value[15:8];
                end
            end
            default:
            begin
                byte_sel = '0;
            end
        endcase
    end

    assign item = '{data: byte_sel, last: (k_reg == last_k_reg), notify: notify};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            kind_reg    <= RK_EXC;
            code_reg    <= '0;
            start_reg   <= '0;
            count_reg   <= '0;
            addr_reg    <= '0;
            k_reg       <= '0;
            last_k_reg  <= '0;
            chk_s_reg   <= '0;
            chk_l_reg   <= '0;
            chk_err_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_pop && !cmd.is_clear)
                    begin
                        start_reg <= cmd.start_addr;
                        count_reg <= cmd.reg_count;
                        addr_reg  <= cmd.start_addr;
                        k_reg     <= '0;
                        state_reg <= ST_EMIT;
                        priority if (cmd.func == FN_READ)
                        begin
                            if (cmd.reg_count > 16'(MAX_READ_COUNT))
                            begin
                                kind_reg   <= RK_EXC;
                                code_reg   <= EXC_COUNT;
                                last_k_reg <= RESP_IDX_W'(1);
                            end
                            else
                            begin
                                kind_reg   <= RK_READ;
                                code_reg   <= FN_READ;
                                last_k_reg <= RESP_IDX_W'({cmd.reg_count, 1'b1});
                            end
                        end
                        else if (cmd.func == FN_WRITE1)
                        begin
                            if (addr_mapped(cmd.start_addr))
                            begin
                                kind_reg   <= RK_ECHO;
                                code_reg   <= FN_WRITE1;
                                last_k_reg <= RESP_IDX_W'(4);
                            end
                            else
                            begin
                                kind_reg   <= RK_EXC;
                                code_reg   <= EXC_ADDR;
                                last_k_reg <= RESP_IDX_W'(1);
                            end
                        end
                        else if (cmd.func == FN_WRITEN)
                        begin
                            chk_s_reg   <= cmd.start_addr + {1'b0, cmd.done};
                            chk_l_reg   <= (cmd.reg_count > {1'b0, cmd.done}) ?
                                           cmd.reg_count - {1'b0, cmd.done} : '0;
                            chk_err_reg <= cmd.write_error;
                            state_reg   <= ST_CHECK;
                        end
                        else
                        begin
                            kind_reg   <= RK_EXC;
                            code_reg   <= EXC_FUNC;
                            last_k_reg <= RESP_IDX_W'(1);
                        end
                    end
                end
                ST_CHECK:
                begin
                    state_reg <= ST_EMIT;
                    if (chk_fail)
                    begin
                        kind_reg   <= RK_EXC;
                        code_reg   <= EXC_ADDR;
                        last_k_reg <= RESP_IDX_W'(1);
                    end
                    else
                    begin
                        kind_reg   <= RK_ECHO;
                        code_reg   <= FN_WRITEN;
                        last_k_reg <= RESP_IDX_W'(4);
                    end
                end
                ST_EMIT:
                begin
                    if (produce)
                    begin
                        k_reg <= k_reg + RESP_IDX_W'(1);
                        if ((kind_reg == RK_READ) && (k_reg >= RESP_IDX_W'(2)) && k_reg[0])
                        begin
                            addr_reg <= addr_reg + 16'd1;
                        end
                        if (k_reg == last_k_reg)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= 1'b0;
            oq_rd_reg  <= 1'b0;
            oq_cnt_reg <= 2'd0;
        end
        else
        begin
            if (produce)
            begin
                oq_reg[oq_wr_reg] <= item;
                oq_wr_reg <= !oq_wr_reg;
            end
            if (oq_pop)
            begin
                oq_rd_reg <= !oq_rd_reg;
            end
            if (produce && !oq_pop)
            begin
                oq_cnt_reg <= oq_cnt_reg + 2'd1;
            end
            else if (oq_pop && !produce)
            begin
                oq_cnt_reg <= oq_cnt_reg - 2'd1;
            end
        end
    end

endmodule

/* rtl/core/modbus_holding_register_server.sv */
// Modbus TCP holding-register server. Request frames enter one byte per transaction; header
// bytes 0-6 are only counted, and at the frame's last byte the response from offset 7 on is
// produced, one byte per result transaction, with resp_last on its final byte. Header and
// field bytes are taken one per cycle even while the previous response drains, as long as the
// two-entry command queue between front and back has room for frame ends and notify clears;
// from byte 13 of a frame on (where multi-register writes land) full holds while the back end
// still produces an earlier response or a command is queued. With the back end idle, a frame's
// last byte is queued as a command, the back end takes it (a multi-register write first checks
// its remaining address range in one step) and the output queue registers the response bytes
// one per cycle, up to 64 bytes for a 31-register read, limited by the pop rate.
module modbus_holding_register_server
    import mhr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic       mode,
    input  logic [7:0] frame_byte,
    input  logic       frame_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] resp_byte,
    output logic       resp_last,
    output logic       write_notify
);

    cmd_t                 fe_cmd;
    cmd_t                 cq_dout;
    logic                 fe_cmd_push;
    logic                 cq_full;
    logic                 cq_empty;
    logic                 be_cmd_pop;
    logic                 be_busy;
    logic                 busy;
    reg_wr_t              fe_wr;
    reg_wr_t              be_wr;
    reg_wr_t              rf_wr;
    logic                 notify_clr;
    logic [REG_IDX_W-1:0] rd_idx;
    logic [15:0]          rd_data;
    logic                 notify;

    assign busy  = be_busy || !cq_empty;
    assign rf_wr = fe_wr.en ? fe_wr : be_wr;

    mhr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .mode       (mode),
        .frame_byte (frame_byte),
        .frame_last (frame_last),
        .busy       (busy),
        .cq_full    (cq_full),
        .full       (full),
        .cmd_push   (fe_cmd_push),
        .cmd        (fe_cmd),
        .reg_wr     (fe_wr)
    );

    mhr_cmd_queue u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fe_cmd_push),
        .din   (fe_cmd),
        .full  (cq_full),
        .pop   (be_cmd_pop),
        .dout  (cq_dout),
        .empty (cq_empty)
    );

    mhr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (!cq_empty),
        .cmd          (cq_dout),
        .cmd_pop      (be_cmd_pop),
        .reg_wr       (be_wr),
        .notify_clr   (notify_clr),
        .rd_idx       (rd_idx),
        .rd_data      (rd_data),
        .notify       (notify),
        .busy         (be_busy),
        .empty        (empty),
        .pop          (pop),
        .resp_byte    (resp_byte),
        .resp_last    (resp_last),
        .write_notify (write_notify)
    );

    mhr_regfile u_regfile (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (rf_wr),
        .notify_clr (notify_clr),
        .rd_idx     (rd_idx),
        .rd_data    (rd_data),
        .notify     (notify)
    );

endmodule

/* tb/modbus_holding_register_server_tb.sv */
`timescale 1ns / 100ps

module modbus_holding_register_server_tb;
    import mhr_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 16;
    localparam int ITEM_TARGET  = 240;
    localparam int STEADY_FROM  = 100;
    localparam int STEADY_TO    = 170;

    typedef logic [7:0] octet_q_t[$];

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       notify;
    } resp_beat_t;

    class register_file_scoreboard;
        logic [15:0] regs [NUM_REGS];
        logic        notify;
        logic [15:0] offset;
        logic [7:0]  func;
        logic [15:0] start_addr;
        logic [15:0] count;
        logic [15:0] word_hold;
        logic        werr;
        octet_q_t    reply;
        resp_beat_t  expected_resp[$];
        int          errors;
        int          checked;
        int          frames;

        function new();
            foreach (regs[i])
                regs[i] = 16'h0000;
            notify  = 1'b0;
            errors  = 0;
            checked = 0;
            frames  = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            offset     = 16'h0000;
            func       = 8'h00;
            start_addr = 16'h0000;
            count      = 16'h0000;
            word_hold  = 16'h0000;
            werr       = 1'b0;
        endfunction

        function bit is_mapped(logic [15:0] a);
            return (a >= 16'd1) && (a <= 16'(NUM_REGS));
        endfunction

        function void store(logic [15:0] a, logic [15:0] v);
            regs[a - 16'd1] = v;
            if (a == 16'(NOTIFY_ADDR))
                notify = 1'b1;
        endfunction

        function void take_octet(logic [7:0] b);
            logic [15:0] idx;
            logic [15:0] a;
            if (offset == OFFSET_MAX)
                return;
            case (offset)
                16'd7:  func = b;
                16'd8:  start_addr[15:8] = b;
                16'd9:  start_addr[7:0] = b;
                16'd10: count[15:8] = b;
                16'd11: count[7:0] = b;
                default:
                begin
                    if (offset >= 16'd13) begin
                        if (offset[0]) begin
                            word_hold = {b, 8'h00};
                        end
                        else begin
                            idx = (offset - 16'd14) >> 1;
                            a   = start_addr + idx;
                            if (func == FN_WRITEN && !werr && idx < count) begin
                                if (is_mapped(a))
                                    store(a, word_hold | {8'h00, b});
                                else
                                    werr = 1'b1;
                            end
                        end
                    end
                end
            endcase
            offset = offset + 16'd1;
        endfunction

        function void respond();
            int          i;
            int          first;
            logic [15:0] a;
            logic [15:0] v;
            reply.delete();
            if (func == FN_READ) begin
                if (count > 16'(MAX_READ_COUNT)) begin
                    reply.push_back(EXC_CODE);
                    reply.push_back(EXC_COUNT);
                end
                else begin
                    reply.push_back(FN_READ);
                    reply.push_back(8'(count * 2));
                    for (i = 0; i < count; i++) begin
                        a = start_addr + 16'(i);
                        v = is_mapped(a) ? regs[a - 16'd1] : UNMAPPED_VALUE;
                        reply.push_back(v[15:8]);
                        reply.push_back(v[7:0]);
                    end
                end
            end
            else if (func == FN_WRITE1) begin
                if (is_mapped(start_addr)) begin
                    store(start_addr, count);
                    reply.push_back(FN_WRITE1);
                    reply.push_back(start_addr[15:8]);
                    reply.push_back(start_addr[7:0]);
                    reply.push_back(count[15:8]);
                    reply.push_back(count[7:0]);
                end
                else begin
                    reply.push_back(EXC_CODE);
                    reply.push_back(EXC_ADDR);
                end
            end
            else if (func == FN_WRITEN) begin
                first = (offset >= 16'd15) ? (int'(offset) - 13) / 2 : 0;
                for (i = first; i < count && !werr; i++) begin
                    if (!is_mapped(start_addr + 16'(i)))
                        werr = 1'b1;
                end
                if (werr) begin
                    reply.push_back(EXC_CODE);
                    reply.push_back(EXC_ADDR);
                end
                else begin
                    reply.push_back(FN_WRITEN);
                    reply.push_back(start_addr[15:8]);
                    reply.push_back(start_addr[7:0]);
                    reply.push_back(count[15:8]);
                    reply.push_back(count[7:0]);
                end
            end
            else begin
                reply.push_back(EXC_CODE);
                reply.push_back(EXC_FUNC);
            end
        endfunction

        function void note_item(logic m, logic [7:0] b, logic l);
            resp_beat_t beat;
            if (m) begin
                notify = 1'b0;
                return;
            end
            take_octet(b);
            if (!l)
                return;
            respond();
            clear_frame();
            frames++;
            foreach (reply[k]) begin
                beat.data   = reply[k];
                beat.last   = (k == reply.size() - 1);
                beat.notify = notify;
                expected_resp.push_back(beat);
            end
        endfunction

        task report_mismatch(string msg);
            $display("ERROR @%0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [7:0] d, logic l, logic n);
            resp_beat_t e;
            checked++;
            if (expected_resp.size() == 0) begin
                report_mismatch($sformatf("response byte %02h with nothing pending", d));
                return;
            end
            e = expected_resp.pop_front();
            if (d !== e.data)
                report_mismatch($sformatf("resp_byte %02h, want %02h", d, e.data));
            if (l !== e.last)
                report_mismatch($sformatf("resp_last %b, want %b", l, e.last));
            if (n !== e.notify)
                report_mismatch($sformatf("write_notify %b, want %b", n, e.notify));
        endtask
    endclass

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       push       = 1'b0;
    logic       mode       = 1'b0;
    logic [7:0] frame_byte = 8'h00;
    logic       frame_last = 1'b0;
    logic       pop        = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] resp_byte;
    logic       resp_last;
    logic       write_notify;

    bit steady      = 1'b0;
    int items_sent  = 0;
    int cycles      = 0;

    register_file_scoreboard regfile_sb = new();

    modbus_holding_register_server u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .mode         (mode),
        .frame_byte   (frame_byte),
        .frame_last   (frame_last),
        .empty        (empty),
        .pop          (pop),
        .resp_byte    (resp_byte),
        .resp_last    (resp_last),
        .write_notify (write_notify)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        pop <= steady || ($urandom_range(0, 99) >= 35);
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            regfile_sb.check_result(resp_byte, resp_last, write_notify);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("modbus_holding_register_server_tb: errors");
            $finish;
        end
    end

    task automatic send_octet(input logic m, input logic [7:0] b, input logic l);
        steady = (items_sent >= STEADY_FROM) && (items_sent < STEADY_TO);
        while (!steady && $urandom_range(0, 99) < 35) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        mode       <= m;
        frame_byte <= b;
        frame_last <= l;
        @(posedge clk);
        while (full)
            @(posedge clk);
        regfile_sb.note_item(m, b, l);
        items_sent++;
    endtask

    // occasional notify clears land mid-frame
    task automatic send_raw(input octet_q_t q);
        foreach (q[i]) begin
            if ($urandom_range(0, 99) < 4)
                send_octet(1'b1, 8'($urandom), 1'($urandom));
            send_octet(1'b0, q[i], i == q.size() - 1);
        end
    endtask

    task automatic send_request(input octet_q_t body);
        octet_q_t q;
        repeat (7)
            q.push_back(8'($urandom));
        foreach (body[i])
            q.push_back(body[i]);
        send_raw(q);
    endtask

    function automatic logic [15:0] pick_addr();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 16'($urandom_range(0, 7));
        else if (r < 85)
            return 16'($urandom_range(16'hFFF8, 16'hFFFF));
        return 16'($urandom);
    endfunction

    task automatic random_frame();
        octet_q_t    body;
        int          kind;
        int          r;
        int          words;
        int          len;
        logic [15:0] a;
        logic [15:0] n;
        kind = $urandom_range(0, 99);
        a    = pick_addr();
        if (kind < 30) begin
            r = $urandom_range(0, 99);
            if (r < 60)
                n = 16'($urandom_range(0, 6));
            else if (r < 85)
                n = 16'($urandom_range(7, 31));
            else
                n = 16'($urandom_range(32, 65535));
            body = '{FN_READ, a[15:8], a[7:0], n[15:8], n[7:0]};
            send_request(body);
        end
        else if (kind < 50) begin
            body = '{FN_WRITE1, a[15:8], a[7:0], 8'($urandom), 8'($urandom)};
            send_request(body);
        end
        else if (kind < 75) begin
            n = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
            words = (n <= 6) ? int'(n) : $urandom_range(0, 4);
            r = $urandom_range(0, 99);
            if (r < 15 && words > 0)
                words = $urandom_range(0, words - 1);
            else if (r < 30)
                words += $urandom_range(1, 2);
            body = '{FN_WRITEN, a[15:8], a[7:0], n[15:8], n[7:0], 8'(words * 2)};
            repeat (2 * words)
                body.push_back(8'($urandom));
            if ($urandom_range(0, 4) == 0)
                body.push_back(8'($urandom));
            send_request(body);
        end
        else if (kind < 88) begin
            len = $urandom_range(1, 13);
            repeat (len)
                body.push_back(8'($urandom));
            if (len > 7) begin
                case ($urandom_range(0, 3))
                    0: body[7] = FN_READ;
                    1: body[7] = FN_WRITE1;
                    2: body[7] = FN_WRITEN;
                    default: ;
                endcase
            end
            send_raw(body);
        end
        else begin
            repeat (5)
                body.push_back(8'($urandom));
            send_request(body);
        end
    endtask

    initial
    begin
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;

        send_request('{FN_READ, 8'h00, 8'h01, 8'h00, 8'h05});
        send_request('{FN_WRITE1, 8'h00, 8'h03, 8'hFF, 8'hFF});
        send_octet(1'b1, 8'hFF, 1'b1);
        send_request('{FN_WRITEN, 8'h00, 8'h01, 8'h00, 8'h05, 8'h0A, 8'h00, 8'h00,
                       8'hA5, 8'hA5, 8'h5A, 8'h5A, 8'hFF, 8'hFF, 8'h12, 8'h34});
        send_request('{FN_READ, 8'hFF, 8'hFE, 8'h00, 8'd31});
        send_request('{FN_READ, 8'h00, 8'h01, 8'h00, 8'd32});
        send_request('{FN_READ, 8'h00, 8'h01, 8'h00, 8'h00});
        send_request('{FN_WRITE1, 8'h00, 8'h00, 8'h12, 8'h34});
        send_request('{FN_WRITEN, 8'h00, 8'h04, 8'h00, 8'h03, 8'h06,
                       8'hDE, 8'hAD, 8'hBE, 8'hEF, 8'hCA, 8'hFE});
        send_request('{FN_WRITEN, 8'h00, 8'h02, 8'h00, 8'h03, 8'h06, 8'h11, 8'h22});
        send_request('{FN_WRITEN, 8'h00, 8'h04, 8'h00, 8'h03, 8'h06, 8'h33, 8'h44});
        send_request('{FN_WRITEN, 8'h00, 8'h05, 8'h00, 8'h01, 8'h02,
                       8'h55, 8'hAA, 8'h66, 8'h77, 8'h99});
        send_raw('{8'h42});
        send_raw('{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, FN_READ, 8'h00});
        send_request('{8'h7F, 8'h00, 8'h01, 8'h00, 8'h01});

        while (items_sent < ITEM_TARGET)
            random_frame();
        steady = 1'b0;
        push <= 1'b0;

        while (regfile_sb.expected_resp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("sent %0d request bytes in %0d frames; checked %0d response bytes",
                 items_sent, regfile_sb.frames, regfile_sb.checked);
        $display("%0d mismatches", regfile_sb.errors);
        if (regfile_sb.errors == 0)
            $display("modbus_holding_register_server_tb: clean");
        else
            $display("modbus_holding_register_server_tb: errors");
        $finish;
    end

endmodule
